// ----- src/json_token_lexer_macros.svh -----
// Assertion macros for the JSON token lexer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define JTL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("json_token_lexer: implication check failed");
// Next-cycle implication.
`define JTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json_token_lexer: next-cycle check failed");
`else
`define JTL_ASSERT_IMPLIES(lbl, ante, cons)
`define JTL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/jtl_pkg.sv -----
// Shared types, codes and character helpers for the JSON token lexer.
// No dependencies; used by every module of the block but jtl_queue.
`timescale 1ns / 1ps

package jtl_pkg;

  // Lexer modes.
  typedef enum logic [3:0] {
    LM_IDLE,
    LM_MINUS,
    LM_ZERO,
    LM_DIGITS,
    LM_DOT,
    LM_STR,
    LM_ESC,
    LM_KW,
    LM_ERR
  } lex_mode_e;

  // What a byte does when it starts a token.
  typedef enum logic [2:0] {
    SC_SPACE,
    SC_PUNCT,
    SC_QUOTE,
    SC_MINUS,
    SC_KEYWORD,
    SC_ZERO,
    SC_DIGIT,
    SC_BAD
  } start_class_e;

  // Input item kinds.
  localparam logic IN_DATA = 1'b0;
  localparam logic IN_END  = 1'b1;

  // Token kinds.
  localparam logic [3:0] TK_NUMBER  = 4'd0;
  localparam logic [3:0] TK_NULL    = 4'd1;
  localparam logic [3:0] TK_BOOLEAN = 4'd2;
  localparam logic [3:0] TK_STRING  = 4'd3;
  localparam logic [3:0] TK_COLON   = 4'd4;
  localparam logic [3:0] TK_COMMA   = 4'd5;
  localparam logic [3:0] TK_LCURLY  = 4'd6;
  localparam logic [3:0] TK_RCURLY  = 4'd7;
  localparam logic [3:0] TK_LSQUARE = 4'd8;
  localparam logic [3:0] TK_RSQUARE = 4'd9;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR     = 3'd1;
  localparam logic [2:0] ERR_LEAD_ZERO    = 3'd2;
  localparam logic [2:0] ERR_MINUS_DIGIT  = 3'd3;
  localparam logic [2:0] ERR_DOT_DIGIT    = 3'd4;
  localparam logic [2:0] ERR_OPEN_STRING  = 3'd5;
  localparam logic [2:0] ERR_BAD_KEYWORD  = 3'd6;

  // Keyword identifiers.
  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  // Characters with a role of their own.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_F         = 8'h66;

  // One result item, first field in the highest bits.
  typedef struct packed {
    logic       stream_end;
    logic [2:0] error_code;
    logic       bool_true;
    logic       token_end;
    logic [7:0] text_char;
    logic       has_char;
    logic [3:0] token_kind;
  } result_t;

  // Queue entry: the results that one input item causes.
  typedef struct packed {
    logic    two;
    result_t second;
    result_t first;
  } entry_t;

  function automatic result_t make_result(input logic [3:0] tk, input logic has,
                                          input logic [7:0] ch, input logic tend,
                                          input logic bt, input logic [2:0] err,
                                          input logic se);
    result_t r;
    r.token_kind = tk;
    r.has_char   = has;
    r.text_char  = ch;
    r.token_end  = tend;
    r.bool_true  = bt;
    r.error_code = err;
    r.stream_end = se;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic start_class_e start_class(input logic [7:0] b);
    start_class_e c;
    case (b)
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: c = SC_SPACE;
      CH_COLON, CH_COMMA, CH_LCURLY, CH_RCURLY,
      CH_LSQUARE, CH_RSQUARE:                   c = SC_PUNCT;
      CH_QUOTE:                                 c = SC_QUOTE;
      CH_MINUS:                                 c = SC_MINUS;
      CH_N, CH_T, CH_F:                         c = SC_KEYWORD;
      CH_ZERO:                                  c = SC_ZERO;
      default: begin
        c = is_digit(b) ? SC_DIGIT : SC_BAD;
      end
    endcase
    return c;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      CH_COLON:   k = TK_COLON;
      CH_COMMA:   k = TK_COMMA;
      CH_LCURLY:  k = TK_LCURLY;
      CH_RCURLY:  k = TK_RCURLY;
      CH_LSQUARE: k = TK_LSQUARE;
      CH_RSQUARE: k = TK_RSQUARE;
      default:    k = TK_NUMBER;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] keyword_id(input logic [7:0] b);
    logic [1:0] w;
    case (b)
      CH_N:    w = KW_NULL;
      CH_T:    w = KW_TRUE;
      default: w = KW_FALSE;
    endcase
    return w;
  endfunction

  // Keyword length; an unknown keyword has length zero and always mismatches.
  function automatic logic [2:0] kw_len(input logic [1:0] w);
    logic [2:0] n;
    case (w)
      KW_NULL:  n = 3'd4;
      KW_TRUE:  n = 3'd4;
      KW_FALSE: n = 3'd5;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // Keyword text, one character per position.
  function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      KW_NULL: begin
        case (p)
          3'd0:    c = CH_N;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      KW_TRUE: begin
        case (p)
          3'd0:    c = CH_T;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (p)
          3'd0:    c = CH_F;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/jtl_front.sv -----
// Front end of the JSON token lexer: accepts bytes, runs the lexer state
// machine and pushes the results of each byte into the queue. Uses jtl_pkg.
`timescale 1ns / 1ps

module jtl_front import jtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] byte_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output entry_t     push_entry_o
);

  lex_mode_e    mode_q, mode_d;
  logic [1:0]   kw_which_q, kw_which_d;
  logic [2:0]   kw_pos_q, kw_pos_d;
  logic         accept;

  start_class_e st_class;
  lex_mode_e    st_mode;
  logic         st_valid;
  result_t      st_res;

  logic         kw_hit;
  logic [2:0]   kw_next_pos;
  logic         kw_done;

  result_t      res_a, res_b;
  logic [1:0]   res_cnt;

  // A byte is taken whenever the queue has room for its results.
  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Token start decode for the current byte.
  always_comb begin
    st_class = start_class(byte_i);
    st_mode  = LM_IDLE;
    st_valid = 1'b0;
    st_res   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE, 1'b0);
    case (st_class)
      SC_SPACE: st_mode = LM_IDLE;
      SC_PUNCT: begin
        st_mode  = LM_IDLE;
        st_valid = 1'b1;
        st_res   = make_result(punct_kind(byte_i), 1'b0, 8'h00, 1'b1, 1'b0,
                               ERR_NONE, 1'b0);
      end
      SC_QUOTE:   st_mode = LM_STR;
      SC_KEYWORD: st_mode = LM_KW;
      SC_MINUS, SC_ZERO, SC_DIGIT: begin
        st_mode  = (st_class == SC_MINUS) ? LM_MINUS :
                   (st_class == SC_ZERO)  ? LM_ZERO  : LM_DIGITS;
        st_valid = 1'b1;
        st_res   = make_result(TK_NUMBER, 1'b1, byte_i, 1'b0, 1'b0, ERR_NONE, 1'b0);
      end
      default: begin
        st_mode  = LM_ERR;
        st_valid = 1'b1;
        st_res   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_BAD_CHAR, 1'b0);
      end
    endcase
  end

  // Keyword matching against the expected character.
  assign kw_hit      = (kw_pos_q < kw_len(kw_which_q)) &&
                       (kw_char(kw_which_q, kw_pos_q) == byte_i);
  assign kw_next_pos = kw_pos_q + 3'd1;
  assign kw_done     = (kw_next_pos == kw_len(kw_which_q));

  // Next-state logic.
  always_comb begin
    mode_d     = mode_q;
    kw_which_d = kw_which_q;
    kw_pos_d   = kw_pos_q;
    if (kind_i == IN_END) begin
      mode_d     = LM_IDLE;
      kw_which_d = KW_NULL;
      kw_pos_d   = 3'd0;
    end else begin
      case (mode_q)
        LM_IDLE: begin
          mode_d = st_mode;
          if (st_class == SC_KEYWORD) begin
            kw_which_d = keyword_id(byte_i);
            kw_pos_d   = 3'd1;
          end
        end
        LM_MINUS: begin
          if (!is_digit(byte_i))       mode_d = LM_ERR;
          else if (byte_i == CH_ZERO)  mode_d = LM_ZERO;
          else                         mode_d = LM_DIGITS;
        end
        LM_ZERO, LM_DIGITS: begin
          if (is_digit(byte_i)) begin
            mode_d = (mode_q == LM_ZERO) ? LM_ERR : LM_DIGITS;
          end else if (byte_i == CH_DOT) begin
            mode_d = LM_DOT;
          end else begin
            // The number ends and this byte starts the next token.
            mode_d = st_mode;
            if (st_class == SC_KEYWORD) begin
              kw_which_d = keyword_id(byte_i);
              kw_pos_d   = 3'd1;
            end
          end
        end
        LM_DOT: mode_d = is_digit(byte_i) ? LM_DIGITS : LM_ERR;
        LM_STR: begin
          if (byte_i == CH_QUOTE)          mode_d = LM_IDLE;
          else if (byte_i == CH_BACKSLASH) mode_d = LM_ESC;
          else                             mode_d = LM_STR;
        end
        LM_ESC: mode_d = LM_STR;
        LM_KW: begin
          if (!kw_hit) begin
            mode_d = LM_ERR;
          end else if (kw_done) begin
            mode_d   = LM_IDLE;
            kw_pos_d = 3'd0;
          end else begin
            kw_pos_d = kw_next_pos;
          end
        end
        default: mode_d = LM_ERR;
      endcase
    end
  end

  // Result logic: up to two results per byte.
  always_comb begin
    res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE, 1'b0);
    res_b   = res_a;
    res_cnt = 2'd0;
    if (kind_i == IN_END) begin
      case (mode_q)
        LM_ZERO, LM_DIGITS: begin
          res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE, 1'b0);
          res_b   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE, 1'b1);
          res_cnt = 2'd2;
        end
        LM_MINUS: begin
          res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_MINUS_DIGIT, 1'b1);
          res_cnt = 2'd1;
        end
        LM_DOT: begin
          res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_DOT_DIGIT, 1'b1);
          res_cnt = 2'd1;
        end
        LM_STR, LM_ESC: begin
          res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_OPEN_STRING, 1'b1);
          res_cnt = 2'd1;
        end
        LM_KW: begin
          res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_BAD_KEYWORD, 1'b1);
          res_cnt = 2'd1;
        end
        default: begin
          res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE, 1'b1);
          res_cnt = 2'd1;
        end
      endcase
    end else begin
      case (mode_q)
        LM_IDLE: begin
          res_a   = st_res;
          res_cnt = {1'b0, st_valid};
        end
        LM_MINUS: begin
          res_a   = is_digit(byte_i) ?
                    make_result(TK_NUMBER, 1'b1, byte_i, 1'b0, 1'b0, ERR_NONE, 1'b0) :
                    make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_MINUS_DIGIT, 1'b0);
          res_cnt = 2'd1;
        end
        LM_ZERO, LM_DIGITS: begin
          if (is_digit(byte_i) && (mode_q == LM_ZERO)) begin
            res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_LEAD_ZERO, 1'b0);
            res_cnt = 2'd1;
          end else if (is_digit(byte_i) || (byte_i == CH_DOT)) begin
            res_a   = make_result(TK_NUMBER, 1'b1, byte_i, 1'b0, 1'b0, ERR_NONE, 1'b0);
            res_cnt = 2'd1;
          end else begin
            res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE, 1'b0);
            res_b   = st_res;
            res_cnt = st_valid ? 2'd2 : 2'd1;
          end
        end
        LM_DOT: begin
          res_a   = is_digit(byte_i) ?
                    make_result(TK_NUMBER, 1'b1, byte_i, 1'b0, 1'b0, ERR_NONE, 1'b0) :
                    make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_DOT_DIGIT, 1'b0);
          res_cnt = 2'd1;
        end
        LM_STR: begin
          res_a   = (byte_i == CH_QUOTE) ?
                    make_result(TK_STRING, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE, 1'b0) :
                    make_result(TK_STRING, 1'b1, byte_i, 1'b0, 1'b0, ERR_NONE, 1'b0);
          res_cnt = 2'd1;
        end
        LM_ESC: begin
          res_a   = make_result(TK_STRING, 1'b1, byte_i, 1'b0, 1'b0, ERR_NONE, 1'b0);
          res_cnt = 2'd1;
        end
        LM_KW: begin
          if (!kw_hit) begin
            res_a   = make_result(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, ERR_BAD_KEYWORD, 1'b0);
            res_cnt = 2'd1;
          end else if (kw_done) begin
            res_a   = (kw_which_q == KW_NULL) ?
                      make_result(TK_NULL, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE, 1'b0) :
                      make_result(TK_BOOLEAN, 1'b0, 8'h00, 1'b1,
                                  (kw_which_q == KW_TRUE), ERR_NONE, 1'b0);
            res_cnt = 2'd1;
          end
        end
        default: res_cnt = 2'd0;
      endcase
    end
  end

  assign push_o              = accept && (res_cnt != 2'd0);
  assign push_entry_o.first  = res_a;
  assign push_entry_o.second = res_b;
  assign push_entry_o.two    = res_cnt[1];

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= LM_IDLE;
      kw_which_q <= KW_NULL;
      kw_pos_q   <= 3'd0;
    end else if (accept) begin
      mode_q     <= mode_d;
      kw_which_q <= kw_which_d;
      kw_pos_q   <= kw_pos_d;
    end
  end

endmodule

// ----- src/jtl_queue.sv -----
// Small register queue between the lexer front end and the output back end.
// Generic over entry width and depth; no package dependency.
`timescale 1ns / 1ps

module jtl_queue #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slots_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- src/jtl_back.sv -----
// Back end of the JSON token lexer: takes queue entries apart and presents
// one result per cycle from an output register unless stalled. Uses jtl_pkg.
`timescale 1ns / 1ps

module jtl_back import jtl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  entry_t  entry_i,
  input  logic    avail_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  result_t out_q, out_d;
  result_t pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  logic    pend_valid_q, pend_valid_d;
  logic    load;

  // The output register can take a new result when empty or being drained.
  assign load = !out_valid_q || out_ready_i;
  assign pop_o = load && !pend_valid_q && avail_i;

  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    if (load) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end else if (avail_i) begin
        out_d        = entry_i.first;
        pend_d       = entry_i.second;
        out_valid_d  = 1'b1;
        pend_valid_d = entry_i.two;
      end else begin
        out_valid_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ----- src/json_token_lexer.sv -----
// Streaming JSON lexer. It takes one byte per cycle on the input stream while
// the queue has room and turns each byte into zero, one or two token results.
// A queue of QUEUE_DEPTH entries, one entry per byte that gives results, parts
// the lexer from the output register, so each side stalls on its own. Bytes
// keep coming in while results wait at the output until that queue is full.
// A byte's first result goes through the queue to the output register. The
// output port moves one result per cycle while the receiver is ready. The end
// of input after a number gives two results, as does a byte ending a number
// with a result of its own: punctuation, minus or a bad character. Bytes in
// strings, numbers and keywords, whitespace and punctuation give one or none.
// After an error the lexer drops bytes until the end-of-input transaction.
// Depends on jtl_pkg, jtl_front, jtl_queue, jtl_back and the macro header.
`timescale 1ns / 1ps
`include "json_token_lexer_macros.svh"

module json_token_lexer import jtl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] text_char, [8] token_end,
                                      // [9] bool_true, [12:10] error_code
  output logic [4:0]  m_axis_tuser,   // [3:0] token_kind, [4] has_char
  output logic        m_axis_tlast    // stream_end
);

  entry_t  push_entry, pop_entry;
  logic    push, pop, q_full, q_empty;
  result_t out_res;

  // Lexer front end.
  jtl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tuser),
    .byte_i       (s_axis_tdata),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Result queue.
  jtl_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Output back end.
  jtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_entry),
    .avail_i     (!q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  // Output packing.
  assign m_axis_tdata = {3'b000, out_res.error_code, out_res.bool_true,
                         out_res.token_end, out_res.text_char};
  assign m_axis_tuser = {out_res.has_char, out_res.token_kind};
  assign m_axis_tlast = out_res.stream_end;

  // The end-of-input result carries no token kind and no text.
  `JTL_ASSERT_IMPLIES(a_end_plain, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 5'd0)
  // An error result mid-stream carries nothing but its code.
  `JTL_ASSERT_IMPLIES(a_err_plain,
                      m_axis_tvalid && !m_axis_tlast && (m_axis_tdata[12:10] != ERR_NONE),
                      (m_axis_tuser == 5'd0) && (m_axis_tdata[9:0] == 10'd0))
  // Text bytes appear only with has_char.
  `JTL_ASSERT_IMPLIES(a_text_gated, m_axis_tvalid && !m_axis_tuser[4], m_axis_tdata[7:0] == 8'h00)
  // An accepted end of input always leaves an entry in the queue.
  `JTL_ASSERT_NEXT(a_end_queued,
                   s_axis_tvalid && s_axis_tready && (s_axis_tuser == IN_END),
                   !q_empty)

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the streaming JSON token lexer.
// Depends on jtl_pkg for the mode enum, token kinds, error codes and characters.
`timescale 1ns / 1ps

module tb;
  import jtl_pkg::*;

  localparam int RAND_ITEMS   = 950;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;

  // One input transaction and one directed table row.
  typedef struct {
    logic       kind;
    logic [7:0] data;
  } lex_item_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_in
  logic        s_axis_tuser = IN_DATA; // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] text_char, [8] token_end,
                                       // [9] bool_true, [12:10] error_code
  logic [4:0]  m_axis_tuser;           // [3:0] token_kind, [4] has_char
  logic        m_axis_tlast;           // stream_end

  json_token_lexer dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Lexer shadow state.
  lex_mode_e  lx_mode = LM_IDLE;
  logic [1:0] kw_sel  = KW_NULL;
  logic [2:0] kw_idx  = 3'd0;

  result_t   step_res[$];
  result_t   expected_tokens[$];
  lex_item_t plan[$];

  int mismatches = 0;
  int useful     = 0;
  int tx_idle    = 13;
  int rx_idle    = 83;

  function automatic result_t mk_res(input logic [3:0] tk, input logic has,
                                     input logic [7:0] ch, input logic tend,
                                     input logic bt, input logic [2:0] err,
                                     input logic se);
    result_t r;
    r.token_kind = tk;
    r.has_char   = has;
    r.text_char  = ch;
    r.token_end  = tend;
    r.bool_true  = bt;
    r.error_code = err;
    r.stream_end = se;
    return r;
  endfunction

  function automatic bit dec_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic string kw_word(input logic [1:0] sel);
    case (sel)
      KW_NULL: return "null";
      KW_TRUE: return "true";
      default: return "false";
    endcase
  endfunction

  // An error result carries only the code; later bytes are dropped.
  task automatic lex_flag(input logic [2:0] err);
    lx_mode = LM_ERR;
    step_res.push_back(mk_res(TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b0, err, 1'b0));
  endtask

  // A byte seen between tokens.
  task automatic lex_start(input logic [7:0] b);
    case (b)
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
      end
      CH_COLON:   step_res.push_back(mk_res(TK_COLON, 0, 0, 1, 0, ERR_NONE, 0));
      CH_COMMA:   step_res.push_back(mk_res(TK_COMMA, 0, 0, 1, 0, ERR_NONE, 0));
      CH_LCURLY:  step_res.push_back(mk_res(TK_LCURLY, 0, 0, 1, 0, ERR_NONE, 0));
      CH_RCURLY:  step_res.push_back(mk_res(TK_RCURLY, 0, 0, 1, 0, ERR_NONE, 0));
      CH_LSQUARE: step_res.push_back(mk_res(TK_LSQUARE, 0, 0, 1, 0, ERR_NONE, 0));
      CH_RSQUARE: step_res.push_back(mk_res(TK_RSQUARE, 0, 0, 1, 0, ERR_NONE, 0));
      CH_QUOTE:   lx_mode = LM_STR;
      CH_MINUS: begin
        lx_mode = LM_MINUS;
        step_res.push_back(mk_res(TK_NUMBER, 1, b, 0, 0, ERR_NONE, 0));
      end
      CH_N, CH_T, CH_F: begin
        kw_sel  = (b == CH_N) ? KW_NULL : (b == CH_T) ? KW_TRUE : KW_FALSE;
        kw_idx  = 3'd1;
        lx_mode = LM_KW;
      end
      default: begin
        if (dec_digit(b)) begin
          lx_mode = (b == CH_ZERO) ? LM_ZERO : LM_DIGITS;
          step_res.push_back(mk_res(TK_NUMBER, 1, b, 0, 0, ERR_NONE, 0));
        end else begin
          lex_flag(ERR_BAD_CHAR);
        end
      end
    endcase
  endtask

  // Advance the shadow lexer by one accepted transaction; results go to step_res.
  task automatic lex_step(input logic kind, input logic [7:0] b);
    logic [2:0] err;
    string      word;
    step_res.delete();
    if (kind == IN_END) begin
      err = ERR_NONE;
      case (lx_mode)
        LM_ZERO, LM_DIGITS:
          step_res.push_back(mk_res(TK_NUMBER, 0, 0, 1, 0, ERR_NONE, 0));
        LM_MINUS:       err = ERR_MINUS_DIGIT;
        LM_DOT:         err = ERR_DOT_DIGIT;
        LM_STR, LM_ESC: err = ERR_OPEN_STRING;
        LM_KW:          err = ERR_BAD_KEYWORD;
        default: begin
        end
      endcase
      step_res.push_back(mk_res(TK_NUMBER, 0, 0, 0, 0, err, 1));
      lx_mode = LM_IDLE;
      kw_sel  = KW_NULL;
      kw_idx  = 3'd0;
    end else begin
      case (lx_mode)
        LM_IDLE: lex_start(b);
        LM_MINUS: begin
          if (!dec_digit(b)) begin
            lex_flag(ERR_MINUS_DIGIT);
          end else begin
            lx_mode = (b == CH_ZERO) ? LM_ZERO : LM_DIGITS;
            step_res.push_back(mk_res(TK_NUMBER, 1, b, 0, 0, ERR_NONE, 0));
          end
        end
        LM_ZERO, LM_DIGITS: begin
          if (dec_digit(b)) begin
            if (lx_mode == LM_ZERO) lex_flag(ERR_LEAD_ZERO);
            else step_res.push_back(mk_res(TK_NUMBER, 1, b, 0, 0, ERR_NONE, 0));
          end else if (b == CH_DOT) begin
            lx_mode = LM_DOT;
            step_res.push_back(mk_res(TK_NUMBER, 1, b, 0, 0, ERR_NONE, 0));
          end else begin
            // The byte that ends a number also starts the next token.
            step_res.push_back(mk_res(TK_NUMBER, 0, 0, 1, 0, ERR_NONE, 0));
            lx_mode = LM_IDLE;
            lex_start(b);
          end
        end
        LM_DOT: begin
          if (!dec_digit(b)) begin
            lex_flag(ERR_DOT_DIGIT);
          end else begin
            lx_mode = LM_DIGITS;
            step_res.push_back(mk_res(TK_NUMBER, 1, b, 0, 0, ERR_NONE, 0));
          end
        end
        LM_STR: begin
          if (b == CH_QUOTE) begin
            lx_mode = LM_IDLE;
            step_res.push_back(mk_res(TK_STRING, 0, 0, 1, 0, ERR_NONE, 0));
          end else begin
            if (b == CH_BACKSLASH) lx_mode = LM_ESC;
            step_res.push_back(mk_res(TK_STRING, 1, b, 0, 0, ERR_NONE, 0));
          end
        end
        LM_ESC: begin
          lx_mode = LM_STR;
          step_res.push_back(mk_res(TK_STRING, 1, b, 0, 0, ERR_NONE, 0));
        end
        LM_KW: begin
          word = kw_word(kw_sel);
          if (kw_idx >= word.len() || word[kw_idx] != b) begin
            lex_flag(ERR_BAD_KEYWORD);
          end else begin
            kw_idx = kw_idx + 3'd1;
            if (kw_idx >= word.len()) begin
              lx_mode = LM_IDLE;
              kw_idx  = 3'd0;
              if (kw_sel == KW_NULL)
                step_res.push_back(mk_res(TK_NULL, 0, 0, 1, 0, ERR_NONE, 0));
              else
                step_res.push_back(mk_res(TK_BOOLEAN, 0, 0, 1, kw_sel == KW_TRUE,
                                          ERR_NONE, 0));
            end
          end
        end
        default: lx_mode = LM_ERR;
      endcase
    end
  endtask

  // Idle settings follow the progress of the run.
  task automatic pick_phase();
    if (useful < RAND_ITEMS / 3) begin
      tx_idle = 13;
      rx_idle = 83;
    end else if (useful < 2 * RAND_ITEMS / 3) begin
      tx_idle = 83;
      rx_idle = 13;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
  endtask

  // Drive one transaction and wait until the lexer accepts it.
  task automatic send_item(input logic kind, input logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    useful++;
  endtask

  task automatic plan_byte(input logic [7:0] b);
    lex_item_t it;
    it.kind = IN_DATA;
    it.data = b;
    plan.push_back(it);
  endtask

  task automatic plan_end();
    lex_item_t it;
    it.kind = IN_END;
    it.data = 8'($urandom_range(255));
    plan.push_back(it);
  endtask

  function automatic logic [7:0] rand_punct();
    logic [7:0] p[6] = '{CH_COLON, CH_COMMA, CH_LCURLY, CH_RCURLY, CH_LSQUARE, CH_RSQUARE};
    return p[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] s[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    return s[$urandom_range(5)];
  endfunction

  // One input document: mostly well-formed tokens, some broken ones and noise.
  task automatic plan_document();
    int         ntok;
    int         pick;
    int         len;
    logic [7:0] c;
    string      word;
    ntok = $urandom_range(20, 3);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++) plan_byte(rand_space());
      end else if (pick < 35) begin
        plan_byte(rand_punct());
      end else if (pick < 55) begin
        // Quotes and backslashes in the content are escaped.
        plan_byte(CH_QUOTE);
        len = $urandom_range(6, 0);
        for (int i = 0; i < len; i++) begin
          c = 8'($urandom_range(255));
          if (c == CH_QUOTE || c == CH_BACKSLASH || $urandom_range(9) == 0)
            plan_byte(CH_BACKSLASH);
          plan_byte(c);
        end
        plan_byte(CH_QUOTE);
      end else if (pick < 75) begin
        if ($urandom_range(99) < 30) plan_byte(CH_MINUS);
        if ($urandom_range(99) < 20) begin
          plan_byte(CH_ZERO);
        end else begin
          plan_byte(8'("0" + $urandom_range(9, 1)));
          len = $urandom_range(4, 0);
          for (int i = 0; i < len; i++) plan_byte(8'("0" + $urandom_range(9)));
        end
        if ($urandom_range(99) < 40) begin
          plan_byte(CH_DOT);
          len = $urandom_range(3, 1);
          for (int i = 0; i < len; i++) plan_byte(8'("0" + $urandom_range(9)));
        end
      end else if (pick < 90) begin
        word = kw_word(2'($urandom_range(2)));
        for (int i = 0; i < word.len(); i++) plan_byte(word[i]);
      end else if (pick < 96) begin
        case ($urandom_range(5))
          0: begin
            // Keyword cut short.
            word = kw_word(2'($urandom_range(2)));
            len = $urandom_range(word.len() - 1, 1);
            for (int i = 0; i < len; i++) plan_byte(word[i]);
            plan_byte(rand_punct());
          end
          1: begin
            // Keyword with one character replaced.
            word = kw_word(2'($urandom_range(2)));
            len = $urandom_range(word.len() - 1, 1);
            for (int i = 0; i < word.len(); i++)
              plan_byte(i == len ? 8'($urandom_range(255)) : word[i]);
          end
          2: begin
            plan_byte(CH_MINUS);
            plan_byte(rand_punct());
          end
          3: begin
            plan_byte(8'("0" + $urandom_range(9)));
            plan_byte(CH_DOT);
            plan_byte(rand_punct());
          end
          4: begin
            plan_byte(CH_ZERO);
            plan_byte(8'("0" + $urandom_range(9)));
          end
          default: begin
            // Input ends inside a token.
            case ($urandom_range(3))
              0: plan_byte(CH_QUOTE);
              1: plan_byte(CH_MINUS);
              2: plan_byte(CH_T);
              default: begin
                plan_byte(8'("0" + $urandom_range(9)));
                plan_byte(CH_DOT);
              end
            endcase
            plan_end();
          end
        endcase
      end else begin
        plan_byte(8'($urandom_range(255)));
      end
    end
    plan_end();
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= rx_idle);
  end

  // Compare each output transaction with the oldest expected token result.
  always @(posedge clk) begin : check_out
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.token_kind = m_axis_tuser[3:0];
      got.has_char   = m_axis_tuser[4];
      got.text_char  = m_axis_tdata[7:0];
      got.token_end  = m_axis_tdata[8];
      got.bool_true  = m_axis_tdata[9];
      got.error_code = m_axis_tdata[12:10];
      got.stream_end = m_axis_tlast;
      if (expected_tokens.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d char=%h err=%0d last=%b",
                   $realtime, got.token_kind, got.text_char, got.error_code,
                   got.stream_end);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.has_char !== want.has_char ||
            got.text_char !== want.text_char || got.token_end !== want.token_end ||
            got.bool_true !== want.bool_true || got.error_code !== want.error_code ||
            got.stream_end !== want.stream_end) begin
          // Fields: kind/has/char/end/bool/err/last.
          if (mismatches < MAX_REPORTS)
            $display("%0t: expected %0d/%b/%h/%b/%b/%0d/%b actual %0d/%b/%h/%b/%b/%0d/%b",
                     $realtime, want.token_kind, want.has_char, want.text_char,
                     want.token_end, want.bool_true, want.error_code, want.stream_end,
                     got.token_kind, got.has_char, got.text_char, got.token_end,
                     got.bool_true, got.error_code, got.stream_end);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random documents, drain.
  initial begin : main
    stim_row_t dir_table[$];
    lex_item_t it;
    dir_table = '{
      // End of input right after reset.
      '{IN_END,  8'h00, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_NONE, 1)},
      // Byte above 127 is a bad character; the next end carries no code.
      '{IN_DATA, 8'hFF, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_BAD_CHAR, 0)},
      '{IN_END,  8'hFF, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_NONE, 1)},
      '{IN_DATA, CH_LSQUARE, 1'b1, mk_res(TK_LSQUARE, 0, 0, 1, 0, ERR_NONE, 0)},
      // String with an escaped quote and a zero byte, left open.
      '{IN_DATA, CH_QUOTE, 1'b0, '0},
      '{IN_DATA, CH_BACKSLASH, 1'b0, '0},
      '{IN_DATA, CH_QUOTE, 1'b0, '0},
      '{IN_DATA, 8'h00, 1'b0, '0},
      '{IN_END,  8'h00, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_OPEN_STRING, 1)},
      // Number ended by punctuation: two results for one byte.
      '{IN_DATA, CH_MINUS, 1'b0, '0},
      '{IN_DATA, CH_ZERO, 1'b0, '0},
      '{IN_DATA, CH_DOT, 1'b0, '0},
      '{IN_DATA, CH_NINE, 1'b0, '0},
      '{IN_DATA, CH_RSQUARE, 1'b0, '0},
      // Leading zero.
      '{IN_DATA, CH_ZERO, 1'b0, '0},
      '{IN_DATA, "1", 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_LEAD_ZERO, 0)},
      '{IN_END,  8'h00, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_NONE, 1)},
      // Keyword mismatch.
      '{IN_DATA, CH_F, 1'b0, '0},
      '{IN_DATA, "x", 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_BAD_KEYWORD, 0)},
      '{IN_END,  8'h00, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_NONE, 1)},
      // Input ends after a minus, then after a dot.
      '{IN_DATA, CH_MINUS, 1'b0, '0},
      '{IN_END,  8'h00, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_MINUS_DIGIT, 1)},
      '{IN_DATA, "5", 1'b0, '0},
      '{IN_DATA, CH_DOT, 1'b0, '0},
      '{IN_END,  8'h00, 1'b1, mk_res(TK_NUMBER, 0, 0, 0, 0, ERR_DOT_DIGIT, 1)},
      // Keyword true, then a number closed by end of input.
      '{IN_DATA, CH_T, 1'b0, '0},
      '{IN_DATA, "r", 1'b0, '0},
      '{IN_DATA, "u", 1'b0, '0},
      '{IN_DATA, "e", 1'b1, mk_res(TK_BOOLEAN, 0, 0, 1, 1, ERR_NONE, 0)},
      '{IN_DATA, "7", 1'b0, '0},
      '{IN_END,  8'h00, 1'b0, '0}
    };

    repeat (12) @(negedge clk);
    rst_ni = 1'b1;

    foreach (dir_table[i]) begin
      send_item(dir_table[i].kind, dir_table[i].data);
      lex_step(dir_table[i].kind, dir_table[i].data);
      if (dir_table[i].typed) expected_tokens.push_back(dir_table[i].want);
      else foreach (step_res[j]) expected_tokens.push_back(step_res[j]);
    end

    useful = 0;
    while (useful < RAND_ITEMS) begin
      plan_document();
      while (plan.size() != 0) begin
        it = plan.pop_front();
        pick_phase();
        send_item(it.kind, it.data);
        lex_step(it.kind, it.data);
        foreach (step_res[j]) expected_tokens.push_back(step_res[j]);
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/jtl_pkg.sv
src/jtl_front.sv
src/jtl_queue.sv
src/jtl_back.sv
src/json_token_lexer.sv
verif/tb.sv
